// ===== hw/rtl/stepper_zone_water_sequencer_assert.svh =====
// Assertion macros for the stepper zone watering sequencer.
// The macros sample on clk and are disabled while rst is high.
`ifndef STEPPER_ZONE_WATER_SEQUENCER_ASSERT_SVH
`define STEPPER_ZONE_WATER_SEQUENCER_ASSERT_SVH

// Check that a condition holds on every clock edge.
`define SZWS_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SZWS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/szws_pkg.sv =====
package szws_pkg;

  // Motor geometry and zone count
  localparam int STEPS_REV  = 2048;
  localparam int ZONE_COUNT = 3;
  localparam int POS_W      = 11;   // shaft position, 0 .. STEPS_REV-1
  localparam int HOME_W     = 12;   // homing step count, 0 .. STEPS_REV

  // Register defaults
  localparam logic [15:0] STEP_PERIOD_RESET = 16'd10;
  localparam logic [15:0] PUMP_PULSE_RESET  = 16'd3000;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_PERIOD = 2'd0;
  localparam logic [1:0] CFG_PUMP_PULSE  = 2'd1;
  localparam logic [1:0] CFG_HOME_ZERO   = 2'd2;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_WATER = 2'd2;
  localparam logic [1:0] REQ_HOME  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ZONE  = 2'd1;
  localparam logic [1:0] ST_NO_HOME   = 2'd2;
  localparam logic [1:0] ST_BUSY      = 2'd3;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MOVE  = 3'd1,
    PH_ZMOVE = 3'd2,
    PH_PUMP  = 3'd3,
    PH_HOME  = 3'd4
  } phase_t;

  // Full-step coil table: bit0 A+, bit1 A-, bit2 B+, bit3 B-
  localparam logic [3:0] COIL_ROWS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

  // Zone target positions, (zone+1)/6 of a revolution; only the first ZONE_COUNT are used
  localparam logic [POS_W-1:0] ZONE_TARGET [8] = '{
    POS_W'((1 * STEPS_REV) / 6), POS_W'((2 * STEPS_REV) / 6),
    POS_W'((3 * STEPS_REV) / 6), POS_W'((4 * STEPS_REV) / 6),
    POS_W'((5 * STEPS_REV) / 6), POS_W'((6 * STEPS_REV) / 6),
    POS_W'((7 * STEPS_REV) / 6), POS_W'((8 * STEPS_REV) / 6)
  };

  // One result item
  typedef struct packed {
    logic [3:0]       coil_drive;
    logic             pump_on;
    logic [POS_W-1:0] position;
    logic             busy_res;
    logic [1:0]       status;
  } res_t;

  // Advance the shaft position by one step with wrap
  function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] pos,
                                                input logic ccw);
    logic [POS_W-1:0] r;
    if (ccw) begin
      r = (pos == '0) ? POS_W'(STEPS_REV - 1) : pos - POS_W'(1);
    end else begin
      r = (pos == POS_W'(STEPS_REV - 1)) ? '0 : pos + POS_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/stepper_zone_water_sequencer.sv =====
// Channel   Handshake             Payload
// --------  --------------------  ----------------------------------------------
// input     in_valid / in_ready   req_type, move_ccw, step_count, zone, limit_pressed
// result    out_valid / out_ready coil_drive, pump_on, position, busy_res, status
// config    cfg_write_en          cfg_index, cfg_data (no wait, no read-back)
//
// Every accepted item updates the sequencer state and yields one registered result
// item (in the skid while the output stalls); one item per cycle while in_ready is high.
// A two-entry output buffer (output register plus skid) keeps input open while
// one result waits; in_ready drops only when both entries are full.
// rst (synchronous, active high) restores register defaults, idles the
// sequencer with coils off and position zero, and empties the output buffer.
`include "stepper_zone_water_sequencer_assert.svh"

module stepper_zone_water_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic                      move_ccw,
  input  logic [15:0]               step_count,
  input  logic [2:0]                zone,
  input  logic                      limit_pressed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                coil_drive,
  output logic                      pump_on,
  output logic [szws_pkg::POS_W-1:0] position,
  output logic                      busy_res,
  output logic [1:0]                status,
  input  logic                      cfg_write_en,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);

  // Configuration registers
  logic [15:0] step_period_ticks;
  logic [15:0] pump_pulse_ticks;
  logic        home_stops_at_zero;

  // Sequencer state
  logic [szws_pkg::POS_W-1:0]  shaft_position, shaft_position_next;
  logic [1:0]                  phase_row, phase_row_next;
  szws_pkg::phase_t            sequence_phase, sequence_phase_next;
  logic [15:0]                 steps_left, steps_left_next;
  logic [15:0]                 tick_count, tick_count_next;
  logic [szws_pkg::HOME_W-1:0] home_steps_taken, home_steps_taken_next;
  logic                        step_ccw, step_ccw_next;
  logic                        coils_powered, coils_powered_next;

  // Output buffer
  szws_pkg::res_t res_main, res_skid, res_next;
  logic           skid_valid;

  logic in_accept;
  logic out_accept;

  // Working values for the next-state logic
  logic [1:0]                  stat;
  logic [16:0]                 tick_inc;
  logic                        home_eval;
  logic                        home_first;
  logic [szws_pkg::HOME_W-1:0] home_taken;
  logic                        home_found;
  logic [szws_pkg::POS_W-1:0]  target;
  logic [szws_pkg::HOME_W-1:0] delta;

  assign in_ready   = !skid_valid;
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period_ticks  <= szws_pkg::STEP_PERIOD_RESET;
      pump_pulse_ticks   <= szws_pkg::PUMP_PULSE_RESET;
      home_stops_at_zero <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        szws_pkg::CFG_STEP_PERIOD: step_period_ticks  <= cfg_data;
        szws_pkg::CFG_PUMP_PULSE:  pump_pulse_ticks   <= cfg_data;
        szws_pkg::CFG_HOME_ZERO:   home_stops_at_zero <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Compute the next sequencer state and the result for the current item
  always_comb begin
    shaft_position_next   = shaft_position;
    phase_row_next        = phase_row;
    sequence_phase_next   = sequence_phase;
    steps_left_next       = steps_left;
    tick_count_next       = tick_count;
    home_steps_taken_next = home_steps_taken;
    step_ccw_next         = step_ccw;
    coils_powered_next    = coils_powered;
    stat       = szws_pkg::ST_OK;
    tick_inc   = {1'b0, tick_count} + 17'd1;
    home_eval  = 1'b0;
    home_first = 1'b0;
    target     = szws_pkg::ZONE_TARGET[zone];
    if (target >= shaft_position) begin
      delta = szws_pkg::HOME_W'(target) - szws_pkg::HOME_W'(shaft_position);
    end else begin
      delta = szws_pkg::HOME_W'(target) + szws_pkg::HOME_W'(szws_pkg::STEPS_REV)
              - szws_pkg::HOME_W'(shaft_position);
    end

    if (req_type == szws_pkg::REQ_TICK) begin
      // Count ticks and act when the period or pump time runs out
      if (sequence_phase != szws_pkg::PH_IDLE) begin
        tick_count_next = tick_inc[15:0];
        if (sequence_phase == szws_pkg::PH_PUMP) begin
          if (tick_inc >= {1'b0, pump_pulse_ticks}) begin
            home_eval  = 1'b1;
            home_first = 1'b1;
          end
        end else if (tick_inc >= {1'b0, step_period_ticks}) begin
          tick_count_next = '0;
          if (sequence_phase == szws_pkg::PH_HOME) begin
            home_eval = 1'b1;
          end else if (steps_left != '0) begin
            shaft_position_next = szws_pkg::pos_step(shaft_position, step_ccw);
            phase_row_next      = step_ccw ? phase_row - 2'd1 : phase_row + 2'd1;
            coils_powered_next  = 1'b1;
            steps_left_next     = steps_left - 16'd1;
          end else if (sequence_phase == szws_pkg::PH_ZMOVE) begin
            coils_powered_next  = 1'b0;
            sequence_phase_next = szws_pkg::PH_PUMP;
            tick_count_next     = '0;
          end else begin
            coils_powered_next  = 1'b0;
            sequence_phase_next = szws_pkg::PH_IDLE;
          end
        end
      end
    end else if (sequence_phase != szws_pkg::PH_IDLE) begin
      // Reject commands while a sequence runs
      stat = szws_pkg::ST_BUSY;
    end else if (req_type == szws_pkg::REQ_MOVE) begin
      if (step_count == '0) begin
        coils_powered_next = 1'b0;
      end else begin
        step_ccw_next       = move_ccw;
        tick_count_next     = '0;
        shaft_position_next = szws_pkg::pos_step(shaft_position, move_ccw);
        phase_row_next      = move_ccw ? phase_row - 2'd1 : phase_row + 2'd1;
        coils_powered_next  = 1'b1;
        steps_left_next     = step_count - 16'd1;
        sequence_phase_next = szws_pkg::PH_MOVE;
      end
    end else if (req_type == szws_pkg::REQ_WATER) begin
      if (zone >= 3'(szws_pkg::ZONE_COUNT)) begin
        stat = szws_pkg::ST_BAD_ZONE;
      end else if (delta == '0) begin
        coils_powered_next  = 1'b0;
        sequence_phase_next = szws_pkg::PH_PUMP;
        tick_count_next     = '0;
      end else begin
        step_ccw_next       = 1'b0;
        tick_count_next     = '0;
        shaft_position_next = szws_pkg::pos_step(shaft_position, 1'b0);
        phase_row_next      = phase_row + 2'd1;
        coils_powered_next  = 1'b1;
        steps_left_next     = 16'(delta - szws_pkg::HOME_W'(1));
        sequence_phase_next = szws_pkg::PH_ZMOVE;
      end
    end else begin
      home_eval  = 1'b1;
      home_first = 1'b1;
    end

    // Check the switch and the step budget, then step CCW or end homing
    home_taken = home_first ? '0 : home_steps_taken;
    home_found = limit_pressed || (home_stops_at_zero && shaft_position == '0);
    if (home_eval) begin
      if (home_first) begin
        sequence_phase_next = szws_pkg::PH_HOME;
        tick_count_next     = '0;
      end
      if (home_found || home_taken >= szws_pkg::HOME_W'(szws_pkg::STEPS_REV)) begin
        shaft_position_next   = '0;
        phase_row_next        = '0;
        coils_powered_next    = 1'b0;
        sequence_phase_next   = szws_pkg::PH_IDLE;
        steps_left_next       = '0;
        home_steps_taken_next = home_taken;
        stat = home_found ? szws_pkg::ST_OK : szws_pkg::ST_NO_HOME;
      end else begin
        shaft_position_next   = szws_pkg::pos_step(shaft_position, 1'b1);
        phase_row_next        = phase_row - 2'd1;
        coils_powered_next    = 1'b1;
        home_steps_taken_next = home_taken + szws_pkg::HOME_W'(1);
      end
    end

    // Form the result item from the new state
    res_next.coil_drive = coils_powered_next ? szws_pkg::COIL_ROWS[phase_row_next] : 4'h0;
    res_next.pump_on    = (sequence_phase_next == szws_pkg::PH_PUMP);
    res_next.position   = shaft_position_next;
    res_next.busy_res   = (sequence_phase_next != szws_pkg::PH_IDLE);
    res_next.status     = stat;
  end

  // Hold the sequencer state; advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      shaft_position   <= '0;
      phase_row        <= '0;
      sequence_phase   <= szws_pkg::PH_IDLE;
      steps_left       <= '0;
      tick_count       <= '0;
      home_steps_taken <= '0;
      step_ccw         <= 1'b0;
      coils_powered    <= 1'b0;
    end else if (in_accept) begin
      shaft_position   <= shaft_position_next;
      phase_row        <= phase_row_next;
      sequence_phase   <= sequence_phase_next;
      steps_left       <= steps_left_next;
      tick_count       <= tick_count_next;
      home_steps_taken <= home_steps_taken_next;
      step_ccw         <= step_ccw_next;
      coils_powered    <= coils_powered_next;
    end
  end

  // Output buffer control: drain the skid first, park a result there on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_accept) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_accept) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (in_accept) begin
        out_valid <= 1'b1;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_accept && skid_valid) begin
      res_main <= res_skid;
    end else if (in_accept && (out_accept || !out_valid)) begin
      res_main <= res_next;
    end
    if (in_accept && out_valid && !out_accept) begin
      res_skid <= res_next;
    end
  end

  assign coil_drive = res_main.coil_drive;
  assign pump_on    = res_main.pump_on;
  assign position   = res_main.position;
  assign busy_res   = res_main.busy_res;
  assign status     = res_main.status;

  // Drop nothing: a parked result always has a result ahead of it
  `SZWS_IMPLY(a_skid_behind_out, skid_valid, out_valid, "skid holds a result with no output ahead")
  // Coils are only energized while a motion is in progress
  `SZWS_IMPLY(a_coils_in_motion, coils_powered,
              sequence_phase == szws_pkg::PH_MOVE || sequence_phase == szws_pkg::PH_ZMOVE ||
              sequence_phase == szws_pkg::PH_HOME, "coils powered outside a motion phase")
  // Homing never takes more than one revolution of steps
  `SZWS_ALWAYS(a_home_bound, home_steps_taken <= szws_pkg::HOME_W'(szws_pkg::STEPS_REV),
               "homing step count exceeds one revolution")

endmodule

// ===== dv/tb.sv =====
module tb;

  localparam int STALL_LIMIT = 1000;

  // One input item as driven on the ports
  typedef struct {
    logic [1:0]  req;
    logic        ccw;
    logic [15:0] count;
    logic [2:0]  zone;
    logic        limit;
  } cmd_t;

  // Sequencer state as the testbench tracks it
  typedef struct {
    logic [szws_pkg::POS_W-1:0]  pos;
    logic [1:0]                  row;
    szws_pkg::phase_t            phase;
    logic [15:0]                 steps_left;
    logic [15:0]                 ticks;
    logic [szws_pkg::HOME_W-1:0] homed;
    logic                        ccw;
    logic                        powered;
    logic [1:0]                  status;
  } seq_state_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 req_type = szws_pkg::REQ_TICK;
  logic                       move_ccw = 1'b0;
  logic [15:0]                step_count = 16'd0;
  logic [2:0]                 zone = 3'd0;
  logic                       limit_pressed = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [3:0]                 coil_drive;
  logic                       pump_on;
  logic [szws_pkg::POS_W-1:0] position;
  logic                       busy_res;
  logic [1:0]                 status;
  logic                       cfg_write_en = 1'b0;
  logic [1:0]                 cfg_index = szws_pkg::CFG_STEP_PERIOD;
  logic [15:0]                cfg_data = 16'd0;

  // Register copies shared by the planner and the driver's predictor
  logic [15:0]         step_period = szws_pkg::STEP_PERIOD_RESET;
  logic [15:0]         pump_pulse = szws_pkg::PUMP_PULSE_RESET;
  logic                home_zero = 1'b1;

  cmd_t                pending_items[$];
  szws_pkg::res_t      due_results[$];
  seq_state_t          seq_now;
  seq_state_t          seq_plan;
  cmd_t                cur;
  szws_pkg::res_t      due;
  szws_pkg::res_t      got;
  int unsigned         items_queued = 0;
  int unsigned         results_seen = 0;
  int unsigned         mismatches = 0;
  int unsigned         quiet_cycles = 0;
  int                  gap_left = 0;
  int                  hold_left = 0;
  logic                calm = 1'b0;

  stepper_zone_water_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .move_ccw      (move_ccw),
    .step_count    (step_count),
    .zone          (zone),
    .limit_pressed (limit_pressed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .coil_drive    (coil_drive),
    .pump_on       (pump_on),
    .position      (position),
    .busy_res      (busy_res),
    .status        (status),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Take one full step and power the coils
  function automatic seq_state_t turn_shaft(seq_state_t s, logic ccw);
    if (ccw) begin
      s.row = s.row - 2'd1;
      s.pos = (s.pos == '0) ? szws_pkg::POS_W'(szws_pkg::STEPS_REV - 1) :
                              s.pos - szws_pkg::POS_W'(1);
    end else begin
      s.row = s.row + 2'd1;
      s.pos = (s.pos == szws_pkg::POS_W'(szws_pkg::STEPS_REV - 1)) ? '0 :
                                                                    s.pos + szws_pkg::POS_W'(1);
    end
    s.powered = 1'b1;
    return s;
  endfunction

  // Clockwise distance from a position to a zone's target
  function automatic int zone_gap(logic [szws_pkg::POS_W-1:0] pos, logic [2:0] zn);
    int target;
    target = ((int'(zn) + 1) * szws_pkg::STEPS_REV) / 6;
    return (target >= int'(pos)) ? target - int'(pos) :
                                   target + szws_pkg::STEPS_REV - int'(pos);
  endfunction

  function automatic seq_state_t begin_pump(seq_state_t s);
    s.powered = 1'b0;
    s.phase = szws_pkg::PH_PUMP;
    s.ticks = '0;
    return s;
  endfunction

  // Stop on the switch or at zero if enabled, give up after one revolution, else step back
  function automatic seq_state_t probe_home(seq_state_t s, logic limit);
    logic found;
    found = limit || (home_zero && s.pos == '0);
    if (found || s.homed >= szws_pkg::HOME_W'(szws_pkg::STEPS_REV)) begin
      s.pos = '0;
      s.row = '0;
      s.powered = 1'b0;
      s.phase = szws_pkg::PH_IDLE;
      s.steps_left = '0;
      s.status = found ? szws_pkg::ST_OK : szws_pkg::ST_NO_HOME;
    end else begin
      s = turn_shaft(s, 1'b1);
      s.homed++;
    end
    return s;
  endfunction

  function automatic seq_state_t begin_home(seq_state_t s, logic limit);
    s.phase = szws_pkg::PH_HOME;
    s.ticks = '0;
    s.homed = '0;
    return probe_home(s, limit);
  endfunction

  // Next sequencer state after one item
  function automatic seq_state_t sequencer_next(seq_state_t s, cmd_t c);
    int gap;
    s.status = szws_pkg::ST_OK;
    if (c.req == szws_pkg::REQ_TICK) begin
      if (s.phase != szws_pkg::PH_IDLE) begin
        s.ticks++;
        if (s.phase == szws_pkg::PH_PUMP) begin
          if (s.ticks >= pump_pulse) s = begin_home(s, c.limit);
        end else if (s.ticks >= step_period) begin
          s.ticks = '0;
          if (s.phase == szws_pkg::PH_HOME) begin
            s = probe_home(s, c.limit);
          end else if (s.steps_left != '0) begin
            s = turn_shaft(s, s.ccw);
            s.steps_left--;
          end else if (s.phase == szws_pkg::PH_ZMOVE) begin
            s = begin_pump(s);
          end else begin
            s.powered = 1'b0;
            s.phase = szws_pkg::PH_IDLE;
          end
        end
      end
    end else if (s.phase != szws_pkg::PH_IDLE) begin
      s.status = szws_pkg::ST_BUSY;
    end else if (c.req == szws_pkg::REQ_MOVE) begin
      if (c.count == '0) begin
        s.powered = 1'b0;
      end else begin
        s.ccw = c.ccw;
        s.ticks = '0;
        s = turn_shaft(s, c.ccw);
        s.steps_left = c.count - 16'd1;
        s.phase = szws_pkg::PH_MOVE;
      end
    end else if (c.req == szws_pkg::REQ_WATER) begin
      if (int'(c.zone) >= szws_pkg::ZONE_COUNT) begin
        s.status = szws_pkg::ST_BAD_ZONE;
      end else begin
        gap = zone_gap(s.pos, c.zone);
        if (gap == 0) begin
          s = begin_pump(s);
        end else begin
          s.ccw = 1'b0;
          s.ticks = '0;
          s = turn_shaft(s, 1'b0);
          s.steps_left = 16'(gap - 1);
          s.phase = szws_pkg::PH_ZMOVE;
        end
      end
    end else begin
      s = begin_home(s, c.limit);
    end
    return s;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.req = 2'($urandom_range(3));
    c.ccw = 1'($urandom_range(1));
    c.count = 16'($urandom);
    c.zone = 3'($urandom_range(7));
    c.limit = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic queue_item(cmd_t c);
    seq_plan = sequencer_next(seq_plan, c);
    pending_items.push_back(c);
    items_queued++;
  endtask

  task automatic queue_cmd(logic [1:0] req, logic ccw, logic [15:0] count, logic [2:0] zn,
                           logic limit);
    cmd_t c;
    c.req = req;
    c.ccw = ccw;
    c.count = count;
    c.zone = zn;
    c.limit = limit;
    queue_item(c);
  endtask

  // Tick with random fields; while homing or pumping the switch closes one time in press_odds
  task automatic queue_tick(int press_odds);
    cmd_t c;
    c = random_cmd();
    c.req = szws_pkg::REQ_TICK;
    if (seq_plan.phase == szws_pkg::PH_HOME || seq_plan.phase == szws_pkg::PH_PUMP) begin
      c.limit = (press_odds != 0) && ($urandom_range(press_odds - 1) == 0);
    end
    queue_item(c);
  endtask

  task automatic finish_sequence(int press_odds);
    while (seq_plan.phase != szws_pkg::PH_IDLE) queue_tick(press_odds);
  endtask

  // Commands when idle, mostly ticks while busy, now and then a command that must bounce
  task automatic random_traffic(int n, int press_odds);
    cmd_t c;
    int unsigned start;
    int pick;
    start = items_queued;
    while (items_queued - start < n) begin
      if (seq_plan.phase == szws_pkg::PH_IDLE) begin
        c = random_cmd();
        pick = $urandom_range(99);
        if (pick < 10) begin
          c.req = szws_pkg::REQ_TICK;
        end else if (pick < 62) begin
          c.req = szws_pkg::REQ_MOVE;
          c.count = ($urandom_range(7) == 0) ? 16'($urandom_range(40)) :
                                               16'($urandom_range(12));
        end else if (pick < 85) begin
          c.req = szws_pkg::REQ_HOME;
          c.limit = ($urandom_range(3) == 0);
        end else begin
          // Only zones past the last one here; a real watering runs far too long
          c.req = szws_pkg::REQ_WATER;
          c.zone = 3'($urandom_range(7, szws_pkg::ZONE_COUNT));
        end
        queue_item(c);
      end else if ($urandom_range(24) == 0) begin
        c = random_cmd();
        if (c.req == szws_pkg::REQ_TICK) c.req = szws_pkg::REQ_HOME;
        queue_item(c);
      end else begin
        queue_tick(press_odds);
      end
    end
    finish_sequence(press_odds);
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] period, logic [15:0] pulse, logic zero_stop);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= szws_pkg::CFG_STEP_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_index <= szws_pkg::CFG_PUMP_PULSE;
    cfg_data <= pulse;
    @(posedge clk);
    cfg_index <= szws_pkg::CFG_HOME_ZERO;
    cfg_data <= {15'd0, zero_stop};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    step_period = period;
    pump_pulse = pulse;
    home_zero = zero_stop;
  endtask

  // Drive items from the pending queue; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        seq_now = sequencer_next(seq_now, cur);
        due.coil_drive = seq_now.powered ? szws_pkg::COIL_ROWS[seq_now.row] : 4'h0;
        due.pump_on = (seq_now.phase == szws_pkg::PH_PUMP);
        due.position = seq_now.pos;
        due.busy_res = (seq_now.phase != szws_pkg::PH_IDLE);
        due.status = seq_now.status;
        due_results.push_back(due);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          in_valid <= 1'b1;
          req_type <= cur.req;
          move_ccw <= cur.ccw;
          step_count <= cur.count;
          zone <= cur.zone;
          limit_pressed <= cur.limit;
          if (!calm && $urandom_range(7) == 0) gap_left = $urandom_range(11, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction and stall the result side in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        got.coil_drive = coil_drive;
        got.pump_on = pump_on;
        got.position = position;
        got.busy_res = busy_res;
        got.status = status;
        if (due_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: coil=%h pump=%b pos=%0d busy=%b status=%0d",
                     got.coil_drive, got.pump_on, got.position, got.busy_res, got.status);
          end
          mismatches++;
        end else begin
          due = due_results.pop_front();
          if (got.coil_drive !== due.coil_drive || got.pump_on !== due.pump_on ||
              got.position !== due.position || got.busy_res !== due.busy_res ||
              got.status !== due.status) begin
            if (mismatches < 10) begin
              $display("result %0d: expected coil=%h pump=%b pos=%0d busy=%b status=%0d",
                       results_seen, due.coil_drive, due.pump_on, due.position,
                       due.busy_res, due.status);
              $display("result %0d: actual   coil=%h pump=%b pos=%0d busy=%b status=%0d",
                       results_seen, got.coil_drive, got.pump_on, got.position,
                       got.busy_res, got.status);
            end
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(9) == 0) begin
        hold_left = $urandom_range(11, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    seq_plan = '{pos: '0, row: '0, phase: szws_pkg::PH_IDLE, steps_left: '0, ticks: '0,
                 homed: '0, ccw: 1'b0, powered: 1'b0, status: szws_pkg::ST_OK};
    seq_now = seq_plan;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: idle tick, homing at zero, bad zones, short moves with wrap
    queue_cmd(szws_pkg::REQ_TICK, 1'b0, 16'd0, 3'd0, 1'b0);
    queue_cmd(szws_pkg::REQ_HOME, 1'b0, 16'd0, 3'd0, 1'b0);
    queue_cmd(szws_pkg::REQ_WATER, 1'b0, 16'd0, 3'd3, 1'b0);
    queue_cmd(szws_pkg::REQ_WATER, 1'b1, 16'hFFFF, 3'd7, 1'b1);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b1, 16'd0, 3'd0, 1'b0);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b1, 16'd1, 3'd0, 1'b0);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b0, 16'hFFFF, 3'd7, 1'b1);
    queue_cmd(szws_pkg::REQ_WATER, 1'b0, 16'd0, 3'd1, 1'b0);
    queue_cmd(szws_pkg::REQ_HOME, 1'b1, 16'd0, 3'd0, 1'b1);
    finish_sequence(4);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b0, 16'd1, 3'd0, 1'b0);
    finish_sequence(4);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b1, 16'd2, 3'd0, 1'b0);
    finish_sequence(4);
    queue_cmd(szws_pkg::REQ_HOME, 1'b0, 16'd0, 3'd0, 1'b1);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b0, 16'd3, 3'd0, 1'b0);
    finish_sequence(4);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b1, 16'd5, 3'd0, 1'b0);
    finish_sequence(4);
    queue_cmd(szws_pkg::REQ_HOME, 1'b0, 16'd0, 3'd0, 1'b0);
    finish_sequence(4);
    settle();

    // Fast steps: water at the target already, then water one step short of it
    set_regs(16'd1, 16'd2, 1'b1);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b0, 16'(zone_gap(seq_plan.pos, 3'd0)), 3'd0, 1'b0);
    finish_sequence(0);
    queue_cmd(szws_pkg::REQ_WATER, 1'b0, 16'd0, 3'd0, 1'b0);
    finish_sequence(8);
    queue_cmd(szws_pkg::REQ_MOVE, 1'b0, 16'(zone_gap(seq_plan.pos, 3'd0) - 1), 3'd0, 1'b0);
    finish_sequence(0);
    queue_cmd(szws_pkg::REQ_WATER, 1'b1, 16'd0, 3'd0, 1'b0);
    finish_sequence(8);
    settle();

    // Zero periods and no stop at zero: homing runs until the switch closes or one revolution is used
    set_regs(16'd0, 16'd0, 1'b0);
    random_traffic(160, 16);
    settle();

    set_regs(16'd3, 16'd7, 1'b1);
    random_traffic(160, 16);
    settle();

    // No idling on either side to the end
    calm = 1'b1;
    set_regs(16'd2, 16'd5, 1'b0);
    random_traffic(160, 16);

    while (results_seen != items_queued) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
